>>> rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants of the ascii integer parser
// Character codes, bases, parse phases and the records that travel between
// the classifier, the parse engine and the queues.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int unsigned MAX_LEN_DEF = 255;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned RADIX_W  = 6;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OFFSET_W = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // one classified character
    typedef struct packed {
        logic               is_blank;
        logic               is_zero;
        logic               is_x;
        logic               is_digit;
        logic [RADIX_W-1:0] digit;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] end_offset;
    } t_result;

endpackage

>>> rtl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser: streaming ascii to unsigned 64-bit integer
// Skips whitespace, detects base prefixes and accumulates digits, one
// character per cycle while the result queue has room, one result per string.
// ----------------------------------------------------------------------------
// Usage:
//   input queue: drive i_character and i_last with push; a transfer happens
//   at a clock edge with push high and full low. i_last marks the final
//   character of a string; only that character yields a result.
//   result queue: o_value and o_end_offset hold the oldest result while
//   empty is low; a transfer happens at a clock edge with pop high and
//   empty low.
//   config: cfg_valid/cfg_ready write the radix (cfg_ready is always high);
//   write it only while no string is in flight.
//   Throughput is one character per cycle while the result queue is not
//   full; the multiply-accumulate (64 by 6 bits) in the parse engine is
//   combinational. A final character passes through the item queue; the
//   parse engine writes its result into the result queue at the edge where
//   it takes the item.
//   Reset sets the radix to 10, empties both queues and restarts the parse.
//   When pop is held low the two-entry result queue fills, the engine
//   stops, the two-entry item queue fills and full rises.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
    parameter int unsigned MAX_LEN = aip_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [aip_pkg::CHAR_W-1:0]    i_character,
    input  logic                          i_last,
    output logic                          empty,
    input  logic                          pop,
    output logic [aip_pkg::VALUE_W-1:0]   o_value,
    output logic [aip_pkg::OFFSET_W-1:0]  o_end_offset,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aip_pkg::RADIX_W-1:0]   i_cfg_radix
);
    import aip_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 2;

    logic [RADIX_W-1:0] r_radix;
    t_item              front_item, back_item;
    logic               item_push, item_full, item_empty, item_pop;
    t_result            back_result, head_result;
    logic               res_push, res_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            r_radix <= i_cfg_radix;
        end
    end

    aip_front u_front (
        .i_push      (push),
        .i_character (i_character),
        .i_last      (i_last),
        .i_q_full    (item_full),
        .o_full      (full),
        .o_q_push    (item_push),
        .o_item      (front_item)
    );

    aip_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (front_item),
        .o_full  (item_full),
        .i_pop   (item_pop),
        .o_data  (back_item),
        .o_empty (item_empty)
    );

    aip_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radix      (r_radix),
        .i_item       (back_item),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_result     (back_result)
    );

    aip_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (head_result),
        .o_empty (empty)
    );

    assign o_value      = head_result.value;
    assign o_end_offset = head_result.end_offset;

endmodule

>>> rtl/aip_queue.sv
// ----------------------------------------------------------------------------
// aip_queue: small register queue
// First-in first-out buffer in flip-flops; the head entry is shown while
// o_empty is low.
// ----------------------------------------------------------------------------
module aip_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

>>> rtl/aip_front.sv
// ----------------------------------------------------------------------------
// aip_front: character classifier
// Takes input characters and turns each into a classified item for the
// parse engine queue.
// ----------------------------------------------------------------------------
module aip_front (
    input  logic                          i_push,
    input  logic [aip_pkg::CHAR_W-1:0]    i_character,
    input  logic                          i_last,
    input  logic                          i_q_full,
    output logic                          o_full,
    output logic                          o_q_push,
    output aip_pkg::t_item                o_item
);
    import aip_pkg::*;

    logic [CHAR_W-1:0] c;
    logic              is_num, is_lower, is_upper;
    logic [CHAR_W-1:0] dv;

    assign c        = i_character;
    assign is_num   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
    assign is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);

    always_comb begin
        priority if (is_num) begin
            dv = c - CH_ZERO;
        end else if (is_lower) begin
            dv = c - CH_LO_A + LETTER_OFS;
        end else if (is_upper) begin
            dv = c - CH_UP_A + LETTER_OFS;
        end else begin
            dv = '0;
        end
    end

    always_comb begin
        o_item.is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        o_item.is_zero  = (c == CH_ZERO);
        o_item.is_x     = (c == CH_LO_X) || (c == CH_UP_X);
        o_item.is_digit = is_num || is_lower || is_upper;
        o_item.digit    = dv[RADIX_W-1:0];
        o_item.last     = i_last;
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

>>> rtl/aip_back.sv
// ----------------------------------------------------------------------------
// aip_back: parse engine
// Runs the prefix and digit state machine on classified items, one per cycle
// unless res_full, and emits the value and end offset on the final character.
// ----------------------------------------------------------------------------
module aip_back #(
    parameter int unsigned MAX_LEN = aip_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [aip_pkg::RADIX_W-1:0]   i_radix,
    input  aip_pkg::t_item                i_item,
    input  logic                          i_item_empty,
    output logic                          o_item_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output aip_pkg::t_result              o_result
);
    import aip_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
    localparam int unsigned EXT_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;

    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [RADIX_W-1:0] r_base, n_base;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_end, n_end;

    logic                       step;
    logic [POS_W-1:0]           pos_inc;
    logic                       take;
    logic [RADIX_W-1:0]         tbase;
    logic [VALUE_W+RADIX_W-1:0] prod;
    logic [EXT_W-1:0]           end_ext;

    assign step       = !i_item_empty && !i_res_full;
    assign o_item_pop = step;
    assign pos_inc    = (r_pos == POS_W'(MAX_LEN)) ? r_pos : r_pos + 1'b1;
    assign prod       = r_acc * tbase;

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_base  = r_base;
        n_pos   = r_pos;
        n_end   = r_end;
        take    = 1'b0;
        tbase   = r_base;
        end_ext = '0;
        o_res_push = 1'b0;
        o_result.value      = '0;
        o_result.end_offset = '0;
        if (step) begin
            unique case (r_phase)
                PH_SPACE: begin
                    if (i_item.is_blank) begin
                        n_end = pos_inc;
                    end else if ((i_radix == RADIX_AUTO || i_radix == BASE_HEX)
                                 && i_item.is_zero) begin
                        n_acc   = '0;
                        n_end   = pos_inc;
                        n_phase = PH_ZERO;
                    end else begin
                        tbase  = (i_radix == RADIX_AUTO) ? BASE_DEC : i_radix;
                        n_base = tbase;
                        take   = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_item.is_x) begin
                        n_base  = BASE_HEX;
                        n_end   = pos_inc;
                        n_phase = PH_DIGITS;
                    end else begin
                        tbase  = (i_radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
                        n_base = tbase;
                        take   = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    take = 1'b1;
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
            if (take) begin
                if (i_item.is_digit && (i_item.digit < tbase)) begin
                    n_acc   = prod[VALUE_W-1:0] + VALUE_W'(i_item.digit);
                    n_end   = pos_inc;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            n_pos = pos_inc;
            if (i_item.last) begin
                end_ext             = EXT_W'(n_end);
                o_res_push          = 1'b1;
                o_result.value      = n_acc;
                o_result.end_offset = end_ext[OFFSET_W-1:0];
                // restart for the next string
                n_phase = PH_SPACE;
                n_acc   = '0;
                n_base  = '0;
                n_pos   = '0;
                n_end   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_base  <= '0;
            r_pos   <= '0;
            r_end   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_end   <= n_end;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_W'(MAX_LEN)) && (r_end <= r_pos))
        else $error("position or end mark out of range");

    a_space_acc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SPACE || r_phase == PH_ZERO) |-> (r_acc == '0))
        else $error("accumulator not clear before digits");

    a_base_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> (r_base != '0))
        else $error("digit phase without a base");

endmodule
